// File: sv/prnds_pkg.sv
// prnds_pkg: widths, status codes, payload structs and the microcode rom
// for the pll reference/feedback divider solver. no dependencies.

package prnds_pkg;

  // datapath and divider widths
  localparam int FreqWidth = 32;
  localparam int RBits     = 14;
  localparam int NBits     = 13;
  localparam int CntW      = $clog2(FreqWidth);

  localparam logic [63:0] RMax64 = (64'd1 << RBits) - 64'd1;
  localparam logic [63:0] NMax64 = (64'd1 << NBits) - 64'd1;

  // result status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StBothZero  = 2'd1;
  localparam logic [1:0] StSaturated = 2'd2;

  typedef struct packed {
    logic [FreqWidth-1:0] ref_hz;
    logic [FreqWidth-1:0] vco_hz;
  } in_t;

  typedef struct packed {
    logic [FreqWidth-1:0] comparison_hz;
    logic [RBits-1:0]     r_count;
    logic [NBits-1:0]     n_count;
    logic [1:0]           status;
  } out_t;

  // microcode
  localparam int PcW = 3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MOD,
    OP_GCD,
    OP_DIV_R,
    OP_DIV_N,
    OP_EMIT,
    OP_EMIT_ZERO
  } op_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_BOTH_ZERO,
    COND_ANY_ZERO
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } uop_t;

  // program addresses
  localparam logic [PcW-1:0] PcEntry    = 3'd0;
  localparam logic [PcW-1:0] PcTest     = 3'd1;
  localparam logic [PcW-1:0] PcMod      = 3'd2;
  localparam logic [PcW-1:0] PcGcd      = 3'd3;
  localparam logic [PcW-1:0] PcDivR     = 3'd4;
  localparam logic [PcW-1:0] PcDivN     = 3'd5;
  localparam logic [PcW-1:0] PcEmit     = 3'd6;
  localparam logic [PcW-1:0] PcEmitZero = 3'd7;

  function automatic uop_t ucode(input logic [PcW-1:0] pc);
    uop_t u;
    unique case (pc)
      PcEntry:    u = '{op: OP_NOP,       cond: COND_BOTH_ZERO, target: PcEmitZero};
      PcTest:     u = '{op: OP_NOP,       cond: COND_ANY_ZERO,  target: PcGcd};
      PcMod:      u = '{op: OP_MOD,       cond: COND_ALWAYS,    target: PcTest};
      PcGcd:      u = '{op: OP_GCD,       cond: COND_NEXT,      target: PcEntry};
      PcDivR:     u = '{op: OP_DIV_R,     cond: COND_NEXT,      target: PcEntry};
      PcDivN:     u = '{op: OP_DIV_N,     cond: COND_NEXT,      target: PcEntry};
      PcEmit:     u = '{op: OP_EMIT,      cond: COND_NEXT,      target: PcEntry};
      PcEmitZero: u = '{op: OP_EMIT_ZERO, cond: COND_NEXT,      target: PcEntry};
      default:    u = '{op: OP_NOP,       cond: COND_NEXT,      target: PcEntry};
    endcase
    return u;
  endfunction

endpackage

// File: sv/pll_ref_n_divider_solver.sv
// pll_ref_n_divider_solver: gcd of reference and vco frequency, then R and N
// dividers. depends on prnds_pkg (widths, structs, microcode rom).
//
// both inputs zero: the entry step jumps straight to a zero result with status StBothZero
// throughput: one item at a time; the bit-serial divider (one quotient bit per
//   cycle, shared by every remainder and both divider quotients) sets the time
// reset: rst_ni async active low, clears sequencer, divider run flag and output valid

module pll_ref_n_divider_solver (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  prnds_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output prnds_pkg::out_t  out_data_o
);

  localparam int FW = prnds_pkg::FreqWidth;

  // sequencer state
  logic                           busy_q, busy_d;
  logic [prnds_pkg::PcW-1:0]      pc_q, pc_d;
  logic                           run_q, run_d;
  logic [prnds_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;

  // datapath registers
  logic [FW-1:0]              a_q, b_q, g_q, ref_q, vco_q;
  logic [FW-1:0]              rem_q, quo_q, dvs_q;
  logic                       mod_sel_q;
  logic [prnds_pkg::RBits-1:0] r_q;
  logic [prnds_pkg::NBits-1:0] n_q;
  logic                       r_sat_q, n_sat_q;
  prnds_pkg::out_t            out_q;

  prnds_pkg::uop_t uop;
  logic            in_xfer, out_free, is_div, div_start, div_last;
  logic            step_done, take_jump, a_ge_b;
  logic [FW-1:0]   dividend, divisor;
  logic [FW:0]     rem_shift, diff;
  logic [FW-1:0]   rem_next, quo_next;
  logic            r_sat, n_sat;

  assign uop      = prnds_pkg::ucode(pc_q);
  assign in_xfer  = in_valid_i && !busy_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign a_ge_b   = (a_q >= b_q);

  assign is_div = (uop.op == prnds_pkg::OP_MOD) || (uop.op == prnds_pkg::OP_DIV_R) ||
                  (uop.op == prnds_pkg::OP_DIV_N);
  assign div_start = busy_q && is_div && !run_q;
  assign div_last  = busy_q && is_div && run_q && (cnt_q == '0);

  // operand select for the shared divider
  always_comb begin
    unique case (uop.op)
      prnds_pkg::OP_MOD: begin
        dividend = a_ge_b ? a_q : b_q;
        divisor  = a_ge_b ? b_q : a_q;
      end
      prnds_pkg::OP_DIV_R: begin
        dividend = ref_q;
        divisor  = g_q;
      end
      prnds_pkg::OP_DIV_N: begin
        dividend = vco_q;
        divisor  = g_q;
      end
      default: begin
        dividend = ref_q;
        divisor  = g_q;
      end
    endcase
  end

  // one restoring divide step per cycle
  always_comb begin
    rem_shift = {rem_q, quo_q[FW-1]};
    diff      = rem_shift - {1'b0, dvs_q};
    if (!diff[FW]) begin
      rem_next = diff[FW-1:0];
      quo_next = {quo_q[FW-2:0], 1'b1};
    end else begin
      rem_next = rem_shift[FW-1:0];
      quo_next = {quo_q[FW-2:0], 1'b0};
    end
  end

  // saturation of the final quotient
  assign r_sat = 64'(quo_next) > prnds_pkg::RMax64;
  assign n_sat = 64'(quo_next) > prnds_pkg::NMax64;

  // microcode sequencer: advance when the step finishes, branch on condition
  always_comb begin
    unique case (uop.op)
      prnds_pkg::OP_MOD, prnds_pkg::OP_DIV_R, prnds_pkg::OP_DIV_N: step_done = div_last;
      prnds_pkg::OP_EMIT, prnds_pkg::OP_EMIT_ZERO:                 step_done = out_free;
      default:                                                     step_done = 1'b1;
    endcase

    unique case (uop.cond)
      prnds_pkg::COND_NEXT:      take_jump = 1'b0;
      prnds_pkg::COND_ALWAYS:    take_jump = 1'b1;
      prnds_pkg::COND_BOTH_ZERO: take_jump = (a_q == '0) && (b_q == '0);
      prnds_pkg::COND_ANY_ZERO:  take_jump = (a_q == '0) || (b_q == '0);
      default:                   take_jump = 1'b0;
    endcase

    busy_d      = busy_q;
    pc_d        = pc_q;
    run_d       = run_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (in_xfer) begin
      busy_d = 1'b1;
      pc_d   = prnds_pkg::PcEntry;
    end else if (busy_q) begin
      if (div_start) begin
        run_d = 1'b1;
        cnt_d = prnds_pkg::CntW'(FW - 1);
      end else if (run_q) begin
        cnt_d = cnt_q - prnds_pkg::CntW'(1);
        if (div_last) begin
          run_d = 1'b0;
        end
      end
      if (step_done) begin
        if ((uop.op == prnds_pkg::OP_EMIT) || (uop.op == prnds_pkg::OP_EMIT_ZERO)) begin
          // result goes to the output register, sequencer returns to idle
          busy_d      = 1'b0;
          out_valid_d = 1'b1;
        end else if (take_jump) begin
          pc_d = uop.target;
        end else begin
          pc_d = pc_q + prnds_pkg::PcW'(1);
        end
      end
    end
  end

  // control state and registered output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= prnds_pkg::PcEntry;
      run_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      run_q       <= run_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ref_q <= FW'(in_data_i.ref_hz);
      vco_q <= FW'(in_data_i.vco_hz);
      a_q   <= FW'(in_data_i.ref_hz);
      b_q   <= FW'(in_data_i.vco_hz);
    end

    if (div_start) begin
      rem_q     <= '0;
      quo_q     <= dividend;
      dvs_q     <= divisor;
      mod_sel_q <= a_ge_b;
    end else if (run_q) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
    end

    // write back at the last divide step
    if (div_last) begin
      unique case (uop.op)
        prnds_pkg::OP_MOD: begin
          if (mod_sel_q) begin
            a_q <= rem_next;
          end else begin
            b_q <= rem_next;
          end
        end
        prnds_pkg::OP_DIV_R: begin
          r_sat_q <= r_sat;
          r_q     <= r_sat ? '1 : prnds_pkg::RBits'(quo_next);
        end
        prnds_pkg::OP_DIV_N: begin
          n_sat_q <= n_sat;
          n_q     <= n_sat ? '1 : prnds_pkg::NBits'(quo_next);
        end
        default: begin
        end
      endcase
    end

    // one of a, b is zero here, so the sum is the gcd
    if (busy_q && (uop.op == prnds_pkg::OP_GCD)) begin
      g_q <= a_q + b_q;
    end

    if (busy_q && out_free && (uop.op == prnds_pkg::OP_EMIT)) begin
      out_q.comparison_hz <= g_q;
      out_q.r_count       <= r_q;
      out_q.n_count       <= n_q;
      out_q.status        <= (r_sat_q || n_sat_q) ? prnds_pkg::StSaturated : prnds_pkg::StOk;
    end else if (busy_q && out_free && (uop.op == prnds_pkg::OP_EMIT_ZERO)) begin
      out_q.comparison_hz <= '0;
      out_q.r_count       <= '0;
      out_q.n_count       <= '0;
      out_q.status        <= prnds_pkg::StBothZero;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/prnds_checker.sv
// prnds_checker: port-level checks for pll_ref_n_divider_solver, bound to it.
// depends on prnds_pkg for the payload structs and status codes.

module prnds_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input prnds_pkg::in_t  in_data_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input prnds_pkg::out_t out_data_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // after an input transfer the block is busy with that item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken but block not busy");

  // both-zero result carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == prnds_pkg::StBothZero) |->
      (out_data_o.comparison_hz == '0) && (out_data_o.r_count == '0) &&
      (out_data_o.n_count == '0))
    else $error("both-zero result with nonzero fields");

  // any other result has a nonzero gcd and at least one nonzero divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != prnds_pkg::StBothZero) |->
      (out_data_o.comparison_hz != '0) &&
      ((out_data_o.r_count != '0) || (out_data_o.n_count != '0)))
    else $error("zero gcd or dividers on a normal result");

  // only defined status codes appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == prnds_pkg::StOk) ||
      (out_data_o.status == prnds_pkg::StBothZero) ||
      (out_data_o.status == prnds_pkg::StSaturated))
    else $error("undefined status code");

endmodule

bind pll_ref_n_divider_solver prnds_checker u_prnds_checker (.*);
